/* sv/entry_review_backoff_assert.svh */
// Assertion macros shared by the entry review backoff design.
`ifndef ENTRY_REVIEW_BACKOFF_ASSERT_SVH
`define ENTRY_REVIEW_BACKOFF_ASSERT_SVH

// Checks cons in the same cycle whenever ante holds.
`define ERB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks cons in the cycle after ante holds.
`define ERB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/erb_pkg.sv */
// Types and constants of the entry review backoff block.
package erb_pkg;

  localparam int THR_W       = 16;
  localparam int MIN_W       = 20;
  localparam int VERDICT_W   = 3;
  localparam int ACTION_W    = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 20;

  localparam logic CMD_VERDICT = 1'b0;
  localparam logic CMD_RETIRE  = 1'b1;

  localparam logic [VERDICT_W-1:0] V_DIRECT       = 3'd0;
  localparam logic [VERDICT_W-1:0] V_BLOCKED      = 3'd1;
  localparam logic [VERDICT_W-1:0] V_DOWN         = 3'd2;
  localparam logic [VERDICT_W-1:0] V_TUNNEL       = 3'd3;
  localparam logic [VERDICT_W-1:0] V_INCONCLUSIVE = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_RETIRE_THRESHOLD     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RETIRE_THRESHOLD_CAP = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_MINUTES         = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CAP_MINUTES          = 2'd3;

  localparam logic [THR_W-1:0] RETIRE_THRESHOLD_RST     = 16'd3;
  localparam logic [THR_W-1:0] RETIRE_THRESHOLD_CAP_RST = 16'd10;
  localparam logic [MIN_W-1:0] BASE_MINUTES_RST         = 20'd60;
  localparam logic [MIN_W-1:0] CAP_MINUTES_RST          = 20'd1440;

  typedef enum logic [ACTION_W-1:0] {
    ACT_KEEP   = 2'd0,
    ACT_RETIRE = 2'd1,
    ACT_HOLD   = 2'd2
  } action_t;

  typedef struct packed {
    logic [THR_W-1:0] retire_threshold;
    logic [THR_W-1:0] retire_threshold_cap;
    logic [MIN_W-1:0] base_minutes;
    logic [MIN_W-1:0] cap_minutes;
  } cfg_t;

endpackage

/* sv/erb_if.sv */
// Valid/ready channel interfaces for verdict beats and result beats.
interface erb_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [erb_pkg::VERDICT_W-1:0] verdict;

  modport source (output valid, output cmd, output verdict, input ready);
  modport sink (input valid, input cmd, input verdict, output ready);
endinterface

interface erb_out_if;
  logic                          valid;
  logic                          ready;
  logic [erb_pkg::ACTION_W-1:0]  action;
  logic [erb_pkg::MIN_W-1:0]     interval_minutes;
  logic [erb_pkg::VERDICT_W-1:0] last_seen;

  modport source (output valid, output action, output interval_minutes, output last_seen,
                  input ready);
  modport sink (input valid, input action, input interval_minutes, input last_seen,
                output ready);
endinterface

/* sv/entry_review_backoff.sv */
// A verdict beat is captured in the input register, then its result is loaded into the result register.
// Throughput: one beat per cycle; a stalled result beat holds the input register,
// so the input ready follows the result ready in the same cycle.
// The per-beat path is the counter update, threshold add/compare and capped shift.
// Reset (rst, synchronous, active high) clears all counters, the last verdict and
// the pipeline valid flags, and restores the configuration register defaults.
module entry_review_backoff #(
  parameter int COUNT_WIDTH   = 32,
  parameter int MAX_DOUBLINGS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [erb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [erb_pkg::CFG_DATA_W-1:0]  cfg_data,
  erb_in_if.sink                          verdicts,
  erb_out_if.source                       results
);

  `include "entry_review_backoff_assert.svh"

  localparam int DW = $clog2(MAX_DOUBLINGS + 1);

  erb_pkg::cfg_t cfg;

  logic                          held_valid;
  logic                          held_cmd;
  logic [erb_pkg::VERDICT_W-1:0] held_verdict;

  logic                          out_valid;
  logic [erb_pkg::ACTION_W-1:0]  out_action;
  logic [erb_pkg::MIN_W-1:0]     out_interval;
  logic [erb_pkg::VERDICT_W-1:0] out_last_seen;

  logic                          in_fire;
  logic                          out_load;
  erb_pkg::action_t              action;
  logic                          run_active;
  logic [DW-1:0]                 doublings;
  logic [erb_pkg::VERDICT_W-1:0] last_seen;
  logic [erb_pkg::MIN_W-1:0]     interval_minutes;
  logic [erb_pkg::MIN_W-1:0]     base_floor;

  erb_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  erb_track #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .MAX_DOUBLINGS (MAX_DOUBLINGS)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .fire       (out_load),
    .cmd        (held_cmd),
    .verdict    (held_verdict),
    .cfg        (cfg),
    .action     (action),
    .run_active (run_active),
    .doublings  (doublings),
    .last_seen  (last_seen)
  );

  erb_interval #(
    .MAX_DOUBLINGS (MAX_DOUBLINGS)
  ) u_interval (
    .run_active       (run_active),
    .doublings        (doublings),
    .base_minutes     (cfg.base_minutes),
    .cap_minutes      (cfg.cap_minutes),
    .interval_minutes (interval_minutes)
  );

  assign out_load       = held_valid && (!out_valid || results.ready);
  assign verdicts.ready = !held_valid || out_load;
  assign in_fire        = verdicts.valid && verdicts.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_fire) begin
      held_valid <= 1'b1;
    end else if (out_load) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_cmd     <= verdicts.cmd;
      held_verdict <= verdicts.verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_action    <= action;
      out_interval  <= interval_minutes;
      out_last_seen <= last_seen;
    end
  end

  assign results.valid            = out_valid;
  assign results.action           = out_action;
  assign results.interval_minutes = out_interval;
  assign results.last_seen        = out_last_seen;

  assign base_floor = (cfg.base_minutes == '0) ? erb_pkg::MIN_W'(1) : cfg.base_minutes;

  `ERB_ASSERT_NOW(a_retire_at_base, results.valid && results.action == erb_pkg::ACT_RETIRE, results.interval_minutes == base_floor, "retirement proposal without base interval")
  `ERB_ASSERT_NOW(a_retire_last_direct, results.valid && results.action == erb_pkg::ACT_RETIRE, results.last_seen == erb_pkg::V_DIRECT, "retirement proposal after non-direct verdict")
  `ERB_ASSERT_NOW(a_interval_nonzero, results.valid, results.interval_minutes != '0, "zero review interval")
  `ERB_ASSERT_NEXT(a_load_shows, out_load, results.valid, "loaded result not presented")

endmodule

/* sv/erb_cfg.sv */
// Configuration register file of the entry review backoff block.
module erb_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            we,
  input  logic [erb_pkg::CFG_INDEX_W-1:0] index,
  input  logic [erb_pkg::CFG_DATA_W-1:0]  data,
  output erb_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retire_threshold     <= erb_pkg::RETIRE_THRESHOLD_RST;
      cfg.retire_threshold_cap <= erb_pkg::RETIRE_THRESHOLD_CAP_RST;
      cfg.base_minutes         <= erb_pkg::BASE_MINUTES_RST;
      cfg.cap_minutes          <= erb_pkg::CAP_MINUTES_RST;
    end else if (we) begin
      case (index)
        erb_pkg::REG_RETIRE_THRESHOLD: begin
          cfg.retire_threshold <= data[erb_pkg::THR_W-1:0];
        end
        erb_pkg::REG_RETIRE_THRESHOLD_CAP: begin
          cfg.retire_threshold_cap <= data[erb_pkg::THR_W-1:0];
        end
        erb_pkg::REG_BASE_MINUTES: begin
          cfg.base_minutes <= data[erb_pkg::MIN_W-1:0];
        end
        erb_pkg::REG_CAP_MINUTES: begin
          cfg.cap_minutes <= data[erb_pkg::MIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/erb_track.sv */
// Health counters, retirement threshold and action decision.
module erb_track #(
  parameter int COUNT_WIDTH   = 32,
  parameter int MAX_DOUBLINGS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     fire,
  input  logic                                     cmd,
  input  logic [erb_pkg::VERDICT_W-1:0]            verdict,
  input  erb_pkg::cfg_t                            cfg,
  output erb_pkg::action_t                         action,
  output logic                                     run_active,
  output logic [$clog2(MAX_DOUBLINGS+1)-1:0]       doublings,
  output logic [erb_pkg::VERDICT_W-1:0]            last_seen
);

  localparam int DW = $clog2(MAX_DOUBLINGS + 1);
  localparam int RW = ((COUNT_WIDTH > erb_pkg::THR_W) ? COUNT_WIDTH : erb_pkg::THR_W) + 1;

  logic [COUNT_WIDTH-1:0]        success_run;
  logic [COUNT_WIDTH-1:0]        block_count;
  logic [COUNT_WIDTH-1:0]        retire_count;
  logic [erb_pkg::VERDICT_W-1:0] last_verdict;

  logic [COUNT_WIDTH-1:0]        success_run_next;
  logic [COUNT_WIDTH-1:0]        block_count_next;
  logic [COUNT_WIDTH-1:0]        retire_count_next;
  logic [erb_pkg::VERDICT_W-1:0] last_verdict_next;

  logic [COUNT_WIDTH-1:0]   run_inc;
  logic [COUNT_WIDTH-1:0]   block_inc;
  logic [COUNT_WIDTH-1:0]   retire_inc;
  logic [erb_pkg::THR_W-1:0] thr_floor;
  logic [erb_pkg::THR_W-1:0] thr_ceil;
  logic [RW-1:0]            thr_raised;
  logic [RW-1:0]            thr_now;

  assign run_inc    = (&success_run) ? success_run : success_run + 1'b1;
  assign block_inc  = (&block_count) ? block_count : block_count + 1'b1;
  assign retire_inc = (&retire_count) ? retire_count : retire_count + 1'b1;

  assign thr_floor  = (cfg.retire_threshold == '0) ? erb_pkg::THR_W'(1)
                                                   : cfg.retire_threshold;
  assign thr_ceil   = (cfg.retire_threshold_cap > thr_floor) ? cfg.retire_threshold_cap
                                                             : thr_floor;
  assign thr_raised = RW'(thr_floor) + RW'(retire_count);
  assign thr_now    = (thr_raised > RW'(thr_ceil)) ? RW'(thr_ceil) : thr_raised;

  always_comb begin
    success_run_next  = success_run;
    block_count_next  = block_count;
    retire_count_next = retire_count;
    last_verdict_next = last_verdict;
    action            = erb_pkg::ACT_HOLD;
    if (cmd == erb_pkg::CMD_RETIRE) begin
      retire_count_next = retire_inc;
      success_run_next  = '0;
      block_count_next  = '0;
      last_verdict_next = erb_pkg::V_DIRECT;
      action            = erb_pkg::ACT_KEEP;
    end else begin
      case (verdict)
        erb_pkg::V_DIRECT: begin
          last_verdict_next = erb_pkg::V_DIRECT;
          block_count_next  = '0;
          success_run_next  = run_inc;
          action = (RW'(run_inc) >= thr_now) ? erb_pkg::ACT_RETIRE : erb_pkg::ACT_KEEP;
        end
        erb_pkg::V_BLOCKED: begin
          last_verdict_next = erb_pkg::V_BLOCKED;
          success_run_next  = '0;
          block_count_next  = block_inc;
          action            = erb_pkg::ACT_KEEP;
        end
        default: begin
          action = erb_pkg::ACT_HOLD;
        end
      endcase
    end
  end

  assign run_active = (success_run_next != '0);
  assign doublings  = (block_count_next < COUNT_WIDTH'(MAX_DOUBLINGS))
                      ? block_count_next[DW-1:0] : DW'(MAX_DOUBLINGS);
  assign last_seen  = last_verdict_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      success_run  <= '0;
      block_count  <= '0;
      retire_count <= '0;
      last_verdict <= erb_pkg::V_DIRECT;
    end else if (fire) begin
      success_run  <= success_run_next;
      block_count  <= block_count_next;
      retire_count <= retire_count_next;
      last_verdict <= last_verdict_next;
    end
  end

endmodule

/* sv/erb_interval.sv */
// Capped exponential review interval from the updated counters.
module erb_interval #(
  parameter int MAX_DOUBLINGS = 16
) (
  input  logic                                run_active,
  input  logic [$clog2(MAX_DOUBLINGS+1)-1:0]  doublings,
  input  logic [erb_pkg::MIN_W-1:0]           base_minutes,
  input  logic [erb_pkg::MIN_W-1:0]           cap_minutes,
  output logic [erb_pkg::MIN_W-1:0]           interval_minutes
);

  localparam int WW = erb_pkg::MIN_W + MAX_DOUBLINGS;

  logic [erb_pkg::MIN_W-1:0] base;
  logic [erb_pkg::MIN_W-1:0] cap;
  logic [WW-1:0]             scaled;

  assign base   = (base_minutes == '0) ? erb_pkg::MIN_W'(1) : base_minutes;
  assign cap    = (cap_minutes < base) ? base : cap_minutes;
  assign scaled = WW'(base) << doublings;

  always_comb begin
    if (run_active) begin
      interval_minutes = base;
    end else if (scaled > WW'(cap)) begin
      interval_minutes = cap;
    end else begin
      interval_minutes = scaled[erb_pkg::MIN_W-1:0];
    end
  end

endmodule

/* tb/sv/tb_entry_review_backoff.sv */
// Self-checking testbench for the entry review backoff block with its own predictor.
module tb_entry_review_backoff;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W       = 32;
  localparam int DOUBLINGS   = 16;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 158;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic                          cmd;
    logic [erb_pkg::VERDICT_W-1:0] verdict;
  } report_t;

  typedef struct {
    erb_pkg::action_t              action;
    logic [erb_pkg::MIN_W-1:0]     interval;
    logic [erb_pkg::VERDICT_W-1:0] seen;
  } review_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [erb_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [erb_pkg::CFG_DATA_W-1:0]  cfg_data;

  erb_in_if  verdicts_ch ();
  erb_out_if results_ch ();

  entry_review_backoff i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .verdicts  (verdicts_ch),
    .results   (results_ch)
  );

  report_t report_backlog[$];
  review_t review_forecast[$];

  erb_pkg::cfg_t    cfg_shadow;
  logic [CNT_W-1:0] run_len;
  logic [CNT_W-1:0] block_len;
  logic [CNT_W-1:0] retirements;
  logic [erb_pkg::VERDICT_W-1:0] last_vd;

  int  mismatches;
  int  cycles;
  int  idle_pct;
  int  send_gap;
  int  take_stall;
  bit  report_taken;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic longint unsigned retire_bar();
    longint unsigned floor_v;
    longint unsigned ceil_v;
    longint unsigned raised;
    floor_v = (cfg_shadow.retire_threshold == '0) ? 1 : cfg_shadow.retire_threshold;
    ceil_v  = (cfg_shadow.retire_threshold_cap > floor_v) ? cfg_shadow.retire_threshold_cap
                                                          : floor_v;
    raised  = floor_v + retirements;
    return (raised > ceil_v) ? ceil_v : raised;
  endfunction

  function automatic logic [erb_pkg::MIN_W-1:0] review_interval();
    longint unsigned base;
    longint unsigned cap;
    longint unsigned grown;
    int shift;
    base = (cfg_shadow.base_minutes == '0) ? 1 : cfg_shadow.base_minutes;
    cap  = (cfg_shadow.cap_minutes < base) ? base : cfg_shadow.cap_minutes;
    if (run_len != '0) begin
      return base[erb_pkg::MIN_W-1:0];
    end
    shift = (block_len < DOUBLINGS) ? int'(block_len) : DOUBLINGS;
    grown = base << shift;
    return (grown > cap) ? cap[erb_pkg::MIN_W-1:0] : grown[erb_pkg::MIN_W-1:0];
  endfunction

  function automatic void apply_review(report_t r);
    review_t exp_r;
    if (r.cmd == erb_pkg::CMD_RETIRE) begin
      retirements = bump(retirements);
      run_len = '0;
      block_len = '0;
      last_vd = erb_pkg::V_DIRECT;
      exp_r.action = erb_pkg::ACT_KEEP;
    end else if (r.verdict == erb_pkg::V_DIRECT) begin
      last_vd = erb_pkg::V_DIRECT;
      block_len = '0;
      run_len = bump(run_len);
      exp_r.action = (run_len >= retire_bar()) ? erb_pkg::ACT_RETIRE : erb_pkg::ACT_KEEP;
    end else if (r.verdict == erb_pkg::V_BLOCKED) begin
      last_vd = erb_pkg::V_BLOCKED;
      run_len = '0;
      block_len = bump(block_len);
      exp_r.action = erb_pkg::ACT_KEEP;
    end else begin
      exp_r.action = erb_pkg::ACT_HOLD;
    end
    exp_r.interval = review_interval();
    exp_r.seen = last_vd;
    review_forecast.push_back(exp_r);
  endfunction

  function automatic void queue_report(logic c, logic [erb_pkg::VERDICT_W-1:0] v);
    report_t r;
    r.cmd = c;
    r.verdict = v;
    report_backlog.push_back(r);
  endfunction

  task automatic add_sequence();
    int kind;
    int len;
    kind = $urandom_range(99);
    if (kind < 40) begin
      len = $urandom_range(12, 1);
      repeat (len) queue_report(erb_pkg::CMD_VERDICT, erb_pkg::V_DIRECT);
      if ($urandom_range(1) == 1) begin
        queue_report(erb_pkg::CMD_RETIRE, erb_pkg::VERDICT_W'($urandom_range(7)));
      end
    end else if (kind < 68) begin
      len = $urandom_range(20, 1);
      repeat (len) queue_report(erb_pkg::CMD_VERDICT, erb_pkg::V_BLOCKED);
    end else if (kind < 78) begin
      queue_report(erb_pkg::CMD_VERDICT, erb_pkg::VERDICT_W'($urandom_range(7, 2)));
    end else if (kind < 88) begin
      queue_report(erb_pkg::CMD_RETIRE, erb_pkg::VERDICT_W'($urandom_range(7)));
    end else begin
      len = $urandom_range(6, 1);
      repeat (len) queue_report(1'($urandom_range(1)), erb_pkg::VERDICT_W'($urandom_range(7)));
    end
  endtask

  task automatic write_reg(logic [erb_pkg::CFG_INDEX_W-1:0] idx,
                           logic [erb_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      erb_pkg::REG_RETIRE_THRESHOLD:
        cfg_shadow.retire_threshold = data[erb_pkg::THR_W-1:0];
      erb_pkg::REG_RETIRE_THRESHOLD_CAP:
        cfg_shadow.retire_threshold_cap = data[erb_pkg::THR_W-1:0];
      erb_pkg::REG_BASE_MINUTES:
        cfg_shadow.base_minutes = data[erb_pkg::MIN_W-1:0];
      erb_pkg::REG_CAP_MINUTES:
        cfg_shadow.cap_minutes = data[erb_pkg::MIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (report_backlog.size() != 0 || verdicts_ch.valid || review_forecast.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Source side: a beat stays presented until it is taken at a rising edge.
  always @(negedge clk) begin
    report_t r;
    if (rst) begin
      verdicts_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!verdicts_ch.valid || report_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        verdicts_ch.valid <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        send_gap = $urandom_range(18, 0);
        verdicts_ch.valid <= 1'b0;
      end else if (report_backlog.size() != 0) begin
        r = report_backlog.pop_front();
        verdicts_ch.valid   <= 1'b1;
        verdicts_ch.cmd     <= r.cmd;
        verdicts_ch.verdict <= r.verdict;
      end else begin
        verdicts_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
      take_stall = 0;
    end else if (take_stall > 0) begin
      take_stall--;
      results_ch.ready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      take_stall = $urandom_range(18, 0);
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    report_t r;
    review_t exp_r;
    cycles++;
    report_taken = !rst && verdicts_ch.valid && verdicts_ch.ready;
    if (report_taken) begin
      r.cmd = verdicts_ch.cmd;
      r.verdict = verdicts_ch.verdict;
      apply_review(r);
    end
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (review_forecast.size() == 0) begin
        $error("result beat with no expected result");
        mismatches++;
      end else begin
        exp_r = review_forecast.pop_front();
        if (results_ch.action !== exp_r.action) begin
          $error("action: expected %0d, actual %0d", exp_r.action, results_ch.action);
          mismatches++;
        end
        if (results_ch.interval_minutes !== exp_r.interval) begin
          $error("interval_minutes: expected %0d, actual %0d", exp_r.interval,
                 results_ch.interval_minutes);
          mismatches++;
        end
        if (results_ch.last_seen !== exp_r.seen) begin
          $error("last_seen: expected %0d, actual %0d", exp_r.seen, results_ch.last_seen);
          mismatches++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    verdicts_ch.valid = 1'b0;
    verdicts_ch.cmd = erb_pkg::CMD_VERDICT;
    verdicts_ch.verdict = erb_pkg::V_DIRECT;
    results_ch.ready = 1'b0;
    report_taken = 1'b0;
    mismatches = 0;
    cycles = 0;
    send_gap = 0;
    take_stall = 0;
    idle_pct = 0;
    cfg_shadow.retire_threshold     = erb_pkg::RETIRE_THRESHOLD_RST;
    cfg_shadow.retire_threshold_cap = erb_pkg::RETIRE_THRESHOLD_CAP_RST;
    cfg_shadow.base_minutes         = erb_pkg::BASE_MINUTES_RST;
    cfg_shadow.cap_minutes          = erb_pkg::CAP_MINUTES_RST;
    run_len = '0;
    block_len = '0;
    retirements = '0;
    last_vd = erb_pkg::V_DIRECT;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Runs up to the default threshold, then one retirement raises it by one.
    repeat (4) queue_report(erb_pkg::CMD_VERDICT, erb_pkg::V_DIRECT);
    queue_report(erb_pkg::CMD_RETIRE, erb_pkg::V_TUNNEL);
    repeat (4) queue_report(erb_pkg::CMD_VERDICT, erb_pkg::V_DIRECT);
    // Repeated blocks double the interval until the cap is hit.
    repeat (6) queue_report(erb_pkg::CMD_VERDICT, erb_pkg::V_BLOCKED);
    for (int v = 2; v < 8; v++) begin
      queue_report(erb_pkg::CMD_VERDICT, erb_pkg::VERDICT_W'(v));
    end
    queue_report(erb_pkg::CMD_RETIRE, 3'd7);
    queue_report(erb_pkg::CMD_RETIRE, erb_pkg::V_DIRECT);
    queue_report(erb_pkg::CMD_VERDICT, erb_pkg::V_DIRECT);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1: begin
            write_reg(erb_pkg::REG_RETIRE_THRESHOLD, '0);
            write_reg(erb_pkg::REG_RETIRE_THRESHOLD_CAP, '0);
            write_reg(erb_pkg::REG_BASE_MINUTES, '0);
            write_reg(erb_pkg::REG_CAP_MINUTES, '0);
          end
          2: begin
            write_reg(erb_pkg::REG_RETIRE_THRESHOLD, '1);
            write_reg(erb_pkg::REG_RETIRE_THRESHOLD_CAP, '1);
            write_reg(erb_pkg::REG_BASE_MINUTES, '1);
            write_reg(erb_pkg::REG_CAP_MINUTES, '1);
          end
          3: begin
            write_reg(erb_pkg::REG_RETIRE_THRESHOLD, 20'd1);
            write_reg(erb_pkg::REG_RETIRE_THRESHOLD_CAP, 20'hFFFF);
            write_reg(erb_pkg::REG_BASE_MINUTES, 20'd1);
            write_reg(erb_pkg::REG_CAP_MINUTES, 20'hFFFFF);
          end
          4: begin
            write_reg(erb_pkg::REG_RETIRE_THRESHOLD, 20'hF0002);
            write_reg(erb_pkg::REG_RETIRE_THRESHOLD_CAP, 20'd6);
            write_reg(erb_pkg::REG_BASE_MINUTES, 20'd3);
            write_reg(erb_pkg::REG_CAP_MINUTES, 20'd100);
          end
          default: begin
            write_reg(erb_pkg::REG_RETIRE_THRESHOLD, erb_pkg::CFG_DATA_W'($urandom_range(8)));
            write_reg(erb_pkg::REG_RETIRE_THRESHOLD_CAP,
                      erb_pkg::CFG_DATA_W'($urandom_range(16)));
            if ($urandom_range(1) == 1) begin
              write_reg(erb_pkg::REG_BASE_MINUTES, erb_pkg::CFG_DATA_W'($urandom_range(1000)));
            end else begin
              write_reg(erb_pkg::REG_BASE_MINUTES, erb_pkg::CFG_DATA_W'($urandom));
            end
            write_reg(erb_pkg::REG_CAP_MINUTES, erb_pkg::CFG_DATA_W'($urandom));
          end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
      end
      case ($urandom_range(3))
        0: idle_pct = 0;
        1: idle_pct = 5;
        2: idle_pct = 20;
        default: idle_pct = 50;
      endcase
      if (p == PHASES - 1) begin
        idle_pct = 0;
      end
      n = 0;
      while (n < PHASE_ITEMS) begin
        n -= report_backlog.size();
        add_sequence();
        n += report_backlog.size();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
